>>> rtl/lpt_pkg.sv
// lpt_pkg: shared constants and command codes for lattice_pivot_transform
// no dependencies
`default_nettype none
package lpt_pkg;

   localparam int DIM         = 3;
   localparam int COORD_WIDTH = 16;

   localparam int FIELD_W     = 16;
   localparam int ENTRY_W     = 8;
   localparam int IDX_W       = 4;
   localparam int CMD_W       = 2;
   localparam int MAT_ROWS    = 3;
   localparam int NUM_ENTRIES = MAT_ROWS * MAT_ROWS;

   localparam int DIFF_W      = FIELD_W + 1;
   localparam int PROD_W      = ENTRY_W + DIFF_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int EXACT_W     = SUM_W + 1;
   localparam int WIDE_W      = 64;
   localparam int WRAP_SHIFT  = WIDE_W - COORD_WIDTH;

   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PIVOT   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_OVERLAP = 2'd2;

endpackage
`default_nettype wire

>>> rtl/lattice_pivot_transform.sv
// lattice_pivot_transform: 3x3 integer matrix-vector product about a pivot point
// depends on lpt_pkg for widths, dimension and command codes
//
// usage:
//   req_* carries one command per transfer: load writes one matrix entry,
//   pivot returns M*(v-p)+p wrapped to the coordinate width with an overflow
//   flag, overlap reports whether M*(v-p) equals the reference vector.
//   rsp_* returns exactly one result per request, in order; load and unused
//   commands return all zeros.
//   a request passes through the difference, product and result registers
//   in turn, the first loaded at the transfer edge.
//   one transfer per cycle unless a held rsp_ready has filled the pipeline;
//   the nine 8x17 multipliers feed a registered three-term sum.
//   a load takes effect for every request accepted after it.
//   reset (synchronous, active high) clears the matrix to zero and empties
//   the pipeline.
//   when the receiver holds rsp_ready low the result register holds, the
//   stages behind it fill, and req_ready drops once all three are full.
`default_nettype none
module lattice_pivot_transform (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire         [lpt_pkg::CMD_W-1:0]         req_command,
   input  wire         [lpt_pkg::IDX_W-1:0]         req_entry_index,
   input  wire  signed [lpt_pkg::ENTRY_W-1:0]       req_entry_value,
   input  wire  signed [lpt_pkg::FIELD_W-1:0]       req_pivot_x,
   input  wire  signed [lpt_pkg::FIELD_W-1:0]       req_pivot_y,
   input  wire  signed [lpt_pkg::FIELD_W-1:0]       req_pivot_z,
   input  wire  signed [lpt_pkg::FIELD_W-1:0]       req_point_x,
   input  wire  signed [lpt_pkg::FIELD_W-1:0]       req_point_y,
   input  wire  signed [lpt_pkg::FIELD_W-1:0]       req_point_z,
   input  wire  signed [lpt_pkg::FIELD_W-1:0]       req_ref_x,
   input  wire  signed [lpt_pkg::FIELD_W-1:0]       req_ref_y,
   input  wire  signed [lpt_pkg::FIELD_W-1:0]       req_ref_z,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic signed [lpt_pkg::FIELD_W-1:0]       rsp_result_x,
   output logic signed [lpt_pkg::FIELD_W-1:0]       rsp_result_y,
   output logic signed [lpt_pkg::FIELD_W-1:0]       rsp_result_z,
   output logic                                    rsp_match,
   output logic                                    rsp_overflow
);
   import lpt_pkg::*;

   // matrix storage
   logic signed [ENTRY_W-1:0] mat_ff [NUM_ENTRIES];

   // stage 1: differences
   logic                      s1_valid_ff;
   logic        [CMD_W-1:0]   s1_cmd_ff;
   logic signed [DIFF_W-1:0]  s1_diff_ff [MAT_ROWS];
   logic signed [FIELD_W-1:0] s1_pivot_ff [MAT_ROWS];
   logic signed [FIELD_W-1:0] s1_ref_ff [MAT_ROWS];
   logic signed [DIFF_W-1:0]  s1_diff_in [MAT_ROWS];

   // stage 2: products
   logic                      s2_valid_ff;
   logic        [CMD_W-1:0]   s2_cmd_ff;
   logic signed [PROD_W-1:0]  s2_prod_ff [NUM_ENTRIES];
   logic signed [FIELD_W-1:0] s2_pivot_ff [MAT_ROWS];
   logic signed [FIELD_W-1:0] s2_ref_ff [MAT_ROWS];
   logic signed [PROD_W-1:0]  s2_prod_in [NUM_ENTRIES];

   // stage 3: result register
   logic                      rsp_valid_ff;
   logic signed [FIELD_W-1:0] res_ff [MAT_ROWS];
   logic                      match_ff;
   logic                      overflow_ff;
   logic signed [FIELD_W-1:0] res_in [MAT_ROWS];
   logic                      match_in;
   logic                      overflow_in;

   logic rsp_adv, s2_adv, s1_adv, req_xfer;

   assign rsp_adv   = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = !s2_valid_ff || rsp_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      s1_diff_in[0] = DIFF_W'(req_point_x) - DIFF_W'(req_pivot_x);
      s1_diff_in[1] = DIFF_W'(req_point_y) - DIFF_W'(req_pivot_y);
      s1_diff_in[2] = DIFF_W'(req_point_z) - DIFF_W'(req_pivot_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            mat_ff[i] <= '0;
         end
      end else if (req_xfer && req_command == CMD_LOAD &&
                   req_entry_index < IDX_W'(NUM_ENTRIES)) begin
         mat_ff[req_entry_index] <= req_entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_cmd_ff      <= req_command;
         s1_diff_ff     <= s1_diff_in;
         s1_pivot_ff[0] <= req_pivot_x;
         s1_pivot_ff[1] <= req_pivot_y;
         s1_pivot_ff[2] <= req_pivot_z;
         s1_ref_ff[0]   <= req_ref_x;
         s1_ref_ff[1]   <= req_ref_y;
         s1_ref_ff[2]   <= req_ref_z;
      end
   end

   always_comb begin
      for (int r = 0; r < MAT_ROWS; r++) begin
         for (int c = 0; c < MAT_ROWS; c++) begin
            if (r < DIM && c < DIM) begin
               s2_prod_in[r*MAT_ROWS+c] = mat_ff[r*MAT_ROWS+c] * s1_diff_ff[c];
            end else begin
               s2_prod_in[r*MAT_ROWS+c] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s1_valid_ff) begin
         s2_cmd_ff   <= s1_cmd_ff;
         s2_prod_ff  <= s2_prod_in;
         s2_pivot_ff <= s1_pivot_ff;
         s2_ref_ff   <= s1_ref_ff;
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0]   sum;
      logic signed [EXACT_W-1:0] exact;
      logic signed [WIDE_W-1:0]  ext;
      logic signed [WIDE_W-1:0]  wrapped;
      logic                      eq;
      logic                      ovf;
      eq  = 1'b1;
      ovf = 1'b0;
      for (int r = 0; r < MAT_ROWS; r++) begin
         sum = '0;
         for (int c = 0; c < MAT_ROWS; c++) begin
            sum = sum + SUM_W'(s2_prod_ff[r*MAT_ROWS+c]);
         end
         exact   = EXACT_W'(sum) + EXACT_W'(s2_pivot_ff[r]);
         ext     = WIDE_W'(exact);
         wrapped = (ext <<< WRAP_SHIFT) >>> WRAP_SHIFT;
         if (r < DIM) begin
            res_in[r] = wrapped[FIELD_W-1:0];
            if (wrapped != ext) begin
               ovf = 1'b1;
            end
            if (sum != SUM_W'(s2_ref_ff[r])) begin
               eq = 1'b0;
            end
         end else begin
            res_in[r] = '0;
         end
      end
      case (s2_cmd_ff)
         CMD_PIVOT: begin
            match_in    = 1'b0;
            overflow_in = ovf;
         end
         CMD_OVERLAP: begin
            res_in[0]   = '0;
            res_in[1]   = '0;
            res_in[2]   = '0;
            match_in    = eq;
            overflow_in = 1'b0;
         end
         default: begin
            res_in[0]   = '0;
            res_in[1]   = '0;
            res_in[2]   = '0;
            match_in    = 1'b0;
            overflow_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_adv) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_adv && s2_valid_ff) begin
         res_ff      <= res_in;
         match_ff    <= match_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_result_x = res_ff[0];
   assign rsp_result_y = res_ff[1];
   assign rsp_result_z = res_ff[2];
   assign rsp_match    = match_ff;
   assign rsp_overflow = overflow_ff;

   // match and overflow come from different commands
   a_match_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && match_ff |-> !overflow_ff)
      else $error("match and overflow both set");

   // an overlap result carries no coordinates
   a_match_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && match_ff |-> res_ff[0] == '0 && res_ff[1] == '0 && res_ff[2] == '0)
      else $error("overlap result with nonzero coordinates");

   // no result appears without an item behind it
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(s2_valid_ff) && !$past(rsp_valid_ff) |-> !rsp_valid_ff)
      else $error("result transfer without a request");

   // input stalls only when the whole pipeline is full and blocked
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && s2_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("request stalled with room in the pipeline");

endmodule
`default_nettype wire

>>> sim/lattice_pivot_transform_test.sv
// lattice_pivot_transform_test: self-checking bench for the 3x3 pivot transform
// predicts every result from its own matrix copy, checks results in order
// depends on lpt_pkg and rtl/lattice_pivot_transform.sv
`timescale 1ns / 1ps
module lattice_pivot_transform_test;
   import lpt_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]              command;
      logic [IDX_W-1:0]              entry_index;
      logic [ENTRY_W-1:0]            entry_value;
      logic [2:0][FIELD_W-1:0]       pivot;
      logic [2:0][FIELD_W-1:0]       point;
      logic [2:0][FIELD_W-1:0]       target;
   } move_request_type;

   typedef struct packed {
      logic [2:0][FIELD_W-1:0]       coord;
      logic                          match;
      logic                          overflow;
   } move_result_type;

   typedef logic [NUM_ENTRIES-1:0][ENTRY_W-1:0] matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic rsp_ready = 1'b0;
   move_request_type req_item = '0;
   wire req_ready;
   wire rsp_valid;
   wire signed [FIELD_W-1:0] rsp_result_x;
   wire signed [FIELD_W-1:0] rsp_result_y;
   wire signed [FIELD_W-1:0] rsp_result_z;
   wire rsp_match;
   wire rsp_overflow;

   matrix_type matrix_copy = '0;
   matrix_type planned_matrix = '0;
   move_result_type predicted_results[$];
   int mismatch_count = 0;
   int moves_sent = 0;
   int rsp_hold_cycles = 0;
   bit sender_idle = 1'b1;
   bit receiver_idle = 1'b1;

   lattice_pivot_transform i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_item.command),
      .req_entry_index (req_item.entry_index),
      .req_entry_value (req_item.entry_value),
      .req_pivot_x     (req_item.pivot[0]),
      .req_pivot_y     (req_item.pivot[1]),
      .req_pivot_z     (req_item.pivot[2]),
      .req_point_x     (req_item.point[0]),
      .req_point_y     (req_item.point[1]),
      .req_point_z     (req_item.point[2]),
      .req_ref_x       (req_item.target[0]),
      .req_ref_y       (req_item.target[1]),
      .req_ref_z       (req_item.target[2]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_x    (rsp_result_x),
      .rsp_result_y    (rsp_result_y),
      .rsp_result_z    (rsp_result_z),
      .rsp_match       (rsp_match),
      .rsp_overflow    (rsp_overflow)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("lattice_pivot_transform_test: FAIL");
      $finish;
   end

   // row of M*(v-p) at full precision
   function automatic longint relative_offset(matrix_type mat, int row,
                                              move_request_type rq);
      longint acc = 0;
      for (int c = 0; c < DIM && c < 3; c++) begin
         acc += longint'(signed'(mat[row * MAT_ROWS + c]))
              * (longint'(signed'(rq.point[c])) - longint'(signed'(rq.pivot[c])));
      end
      return acc;
   endfunction

   function automatic move_result_type predict_move(move_request_type rq);
      move_result_type res;
      longint hi;
      longint lo;
      longint exact;
      longint wrapped;
      res = '0;
      hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
      lo = -(longint'(1) <<< (COORD_WIDTH - 1));
      case (rq.command)
         CMD_LOAD: begin
            if (rq.entry_index < NUM_ENTRIES)
               matrix_copy[rq.entry_index] = rq.entry_value;
         end
         CMD_PIVOT: begin
            for (int k = 0; k < DIM && k < 3; k++) begin
               exact = relative_offset(matrix_copy, k, rq) + longint'(signed'(rq.pivot[k]));
               if (exact > hi || exact < lo)
                  res.overflow = 1'b1;
               wrapped = (exact <<< (64 - COORD_WIDTH)) >>> (64 - COORD_WIDTH);
               res.coord[k] = wrapped[FIELD_W-1:0];
            end
         end
         CMD_OVERLAP: begin
            res.match = 1'b1;
            for (int k = 0; k < DIM && k < 3; k++) begin
               if (relative_offset(matrix_copy, k, rq) != longint'(signed'(rq.target[k])))
                  res.match = 1'b0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic note_mismatch(string what, move_result_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected x=%0d y=%0d z=%0d match=%0b ovf=%0b,",
                  $time, what, $signed(want.coord[0]), $signed(want.coord[1]),
                  $signed(want.coord[2]), want.match, want.overflow,
                  " got x=%0d y=%0d z=%0d match=%0b ovf=%0b",
                  rsp_result_x, rsp_result_y, rsp_result_z, rsp_match, rsp_overflow);
   endtask

   // transfers on both channels, sampled at the rising edge
   always @(posedge clock) begin
      move_result_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            predicted_results.push_back(predict_move(req_item));
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               note_mismatch("result with nothing outstanding", '0);
            end else begin
               want = predicted_results.pop_front();
               if (rsp_result_x !== want.coord[0] || rsp_result_y !== want.coord[1]
                   || rsp_result_z !== want.coord[2] || rsp_match !== want.match
                   || rsp_overflow !== want.overflow)
                  note_mismatch("result mismatch", want);
            end
         end
      end
   end

   // result side: random stalls per transfer, or a long hold when requested
   initial begin
      int stall;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = receiver_idle ? $urandom_range(0, 18) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   function automatic logic [FIELD_W-1:0] random_coord(int span);
      if (span == 0)
         return FIELD_W'($urandom);
      return FIELD_W'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic move_request_type random_request();
      move_request_type rq;
      rq.command = CMD_W'($urandom);
      rq.entry_index = IDX_W'($urandom);
      rq.entry_value = ENTRY_W'($urandom);
      for (int k = 0; k < 3; k++) begin
         rq.pivot[k] = random_coord(0);
         rq.point[k] = random_coord(0);
         rq.target[k] = random_coord(0);
      end
      return rq;
   endfunction

   function automatic move_request_type load_request(int idx, int value);
      move_request_type rq;
      rq = random_request();
      rq.command = CMD_LOAD;
      rq.entry_index = IDX_W'(idx);
      rq.entry_value = ENTRY_W'(value);
      return rq;
   endfunction

   function automatic move_request_type move_request(logic [CMD_W-1:0] cmd,
                                                     int px, int py, int pz,
                                                     int vx, int vy, int vz,
                                                     int tx, int ty, int tz);
      move_request_type rq;
      rq = random_request();
      rq.command = cmd;
      rq.pivot = {FIELD_W'(pz), FIELD_W'(py), FIELD_W'(px)};
      rq.point = {FIELD_W'(vz), FIELD_W'(vy), FIELD_W'(vx)};
      rq.target = {FIELD_W'(tz), FIELD_W'(ty), FIELD_W'(tx)};
      return rq;
   endfunction

   task automatic send_item(move_request_type rq);
      int gap;
      gap = sender_idle ? $urandom_range(0, 18) : 0;
      if (rq.command == CMD_LOAD && rq.entry_index < NUM_ENTRIES)
         planned_matrix[rq.entry_index] = rq.entry_value;
      if (rq.command != CMD_UNUSED && !(rq.command == CMD_LOAD && rq.entry_index >= NUM_ENTRIES))
         moves_sent++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item <= rq;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (predicted_results.size() != 0) @(negedge clock);
   endtask

   task automatic test_zero_matrix();
      send_item(move_request(CMD_PIVOT, 100, -200, 300, 5, 6, 7, 11, 12, 13));
      send_item(move_request(CMD_OVERLAP, -32768, 32767, 0, 32767, -32768, 1, 0, 0, 0));
      send_item(move_request(CMD_OVERLAP, -32768, 32767, 0, 32767, -32768, 1, 0, 0, 1));
   endtask

   task automatic test_matrix_extremes();
      send_item(load_request(0, 1));
      send_item(load_request(4, 1));
      send_item(load_request(8, 1));
      send_item(move_request(CMD_PIVOT, -32768, 32767, 0, 32767, -32768, 0, 0, 0, 0));
      send_item(load_request(0, -128));
      send_item(load_request(8, 127));
      send_item(move_request(CMD_PIVOT, -32768, 0, -32768, 32767, 0, 32767, 0, 0, 0));
      send_item(move_request(CMD_OVERLAP, 0, 0, 0, 1, 0, 0, -128, 0, 0));
      send_item(move_request(CMD_OVERLAP, 0, 0, 0, 1, 0, 1, -128, 0, 126));
      // low bits agree, full value does not
      send_item(move_request(CMD_OVERLAP, 0, 0, -32768, 0, 0, 32767, 0, 0, 127 * 65535));
      send_item(load_request(4, -1));
      send_item(move_request(CMD_PIVOT, 0, 0, 0, 0, -32768, 0, 0, 0, 0));
      send_item(load_request(1, 2));
      send_item(move_request(CMD_PIVOT, 0, 0, 0, 0, 20000, 0, 0, 0, 0));
   endtask

   task automatic test_ignored_items();
      send_item(load_request(9, 127));
      send_item(load_request(15, -1));
      send_item(move_request(CMD_UNUSED, 1, 2, 3, -4, -5, -6, 7, 8, 9));
      send_item(move_request(CMD_PIVOT, 0, 0, 0, 1, 1, 1, 0, 0, 0));
   endtask

   // receiver holds long so the pipeline fills and stalls the request side
   task automatic test_output_stall();
      move_request_type rq;
      sender_idle = 1'b0;
      rsp_hold_cycles = 80;
      for (int i = 0; i < 24; i++) begin
         rq = random_request();
         rq.command = (i % 3 == 2) ? CMD_OVERLAP : CMD_PIVOT;
         send_item(rq);
      end
      wait_for_results();
      sender_idle = 1'b1;
   endtask

   // a matrix load followed by a stream of moves around one pivot, mixed with random items
   task automatic run_chain(int moves);
      move_request_type rq;
      logic [2:0][FIELD_W-1:0] anchor;
      int style;
      int value;
      int pick;
      int span;
      int j;
      style = $urandom_range(0, 3);
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         case (style)
            0, 1: value = $urandom_range(0, 2) - 1;
            2: value = $urandom_range(0, 8) - 4;
            default: value = $urandom_range(0, 255) - 128;
         endcase
         send_item(load_request(i, value));
      end
      for (int k = 0; k < 3; k++)
         anchor[k] = random_coord($urandom_range(0, 1) ? 0 : 2000);
      for (int m = 0; m < moves; m++) begin
         rq = random_request();
         pick = $urandom_range(0, 19);
         if (pick == 1) begin
            rq.command = CMD_LOAD;
            rq.entry_index = IDX_W'($urandom_range(9, 15));
         end else if (pick > 1) begin
            rq.command = (pick < 13) ? CMD_PIVOT : CMD_OVERLAP;
            span = ($urandom_range(0, 4) == 0) ? 0 : 64;
            rq.pivot = anchor;
            for (int k = 0; k < 3; k++)
               rq.point[k] = anchor[k] + random_coord(span);
            if (rq.command == CMD_OVERLAP && $urandom_range(0, 2) != 0) begin
               for (int k = 0; k < 3; k++)
                  rq.target[k] = FIELD_W'(relative_offset(planned_matrix, k, rq));
               if ($urandom_range(0, 3) == 0) begin
                  j = $urandom_range(0, 2);
                  rq.target[j] = rq.target[j] + 1'b1;
               end
            end
         end
         send_item(rq);
      end
   endtask

   task automatic test_random_moves();
      int goal;
      goal = moves_sent + 1700;
      while (moves_sent < goal) begin
         sender_idle = $urandom_range(0, 2) != 0;
         receiver_idle = $urandom_range(0, 2) != 0;
         run_chain($urandom_range(8, 48));
      end
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_zero_matrix();
      test_matrix_extremes();
      test_ignored_items();
      test_output_stall();
      test_random_moves();
      wait_for_results();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && predicted_results.size() == 0)
         $display("lattice_pivot_transform_test: PASS");
      else
         $display("lattice_pivot_transform_test: FAIL");
      $finish;
   end

endmodule

>>> lattice_pivot_transform.f
rtl/lpt_pkg.sv
rtl/lattice_pivot_transform.sv
sim/lattice_pivot_transform_test.sv
